// File: hw/rtl/dwarf_line_program_decoder_macros.svh
// Assertion helper macros
`ifndef DWARF_LINE_PROGRAM_DECODER_MACROS_SVH
`define DWARF_LINE_PROGRAM_DECODER_MACROS_SVH
// implication checked at every edge outside reset
`define DLPD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define DLPD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/dlpd_pkg.sv
//------------------------------------------------------------------------------
// dlpd_pkg
// Shared types and constants for the line-number program decoder.
//------------------------------------------------------------------------------
package dlpd_pkg;
    localparam int EXT_LENGTH_BITS_DEF = 32;

    localparam logic [3:0] PH_OPC     = 4'd0;
    localparam logic [3:0] PH_EXT_LEN = 4'd1;
    localparam logic [3:0] PH_EXT_OP  = 4'd2;
    localparam logic [3:0] PH_EXT_PAY = 4'd3;
    localparam logic [3:0] PH_ULEB    = 4'd4;
    localparam logic [3:0] PH_SLEB    = 4'd5;
    localparam logic [3:0] PH_FIX_LO  = 4'd6;
    localparam logic [3:0] PH_FIX_HI  = 4'd7;
    localparam logic [3:0] PH_DISCARD = 4'd8;
    localparam logic [3:0] PH_ADV     = 4'd9;  // multiply step of address advance
    localparam logic [3:0] PH_SPEC    = 4'd10; // divide steps of special opcode or const_add_pc
    localparam logic [3:0] PH_EMIT    = 4'd11; // deliver result

    localparam logic [1:0] KIND_ROW   = 2'd0;
    localparam logic [1:0] KIND_OVF   = 2'd1;
    localparam logic [1:0] KIND_TRUNC = 2'd2;

    localparam logic [2:0] CFG_MIN_INSTR  = 3'd0;
    localparam logic [2:0] CFG_DEF_STMT   = 3'd1;
    localparam logic [2:0] CFG_LINE_BASE  = 3'd2;
    localparam logic [2:0] CFG_LINE_RANGE = 3'd3;
    localparam logic [2:0] CFG_OPC_BASE   = 3'd4;

    localparam logic [7:0] OP_EXT      = 8'd0;
    localparam logic [7:0] OP_COPY     = 8'd1;
    localparam logic [7:0] OP_ADV_PC   = 8'd2;
    localparam logic [7:0] OP_ADV_LINE = 8'd3;
    localparam logic [7:0] OP_SET_FILE = 8'd4;
    localparam logic [7:0] OP_SET_COL  = 8'd5;
    localparam logic [7:0] OP_NEG_STMT = 8'd6;
    localparam logic [7:0] OP_CONST_PC = 8'd8;
    localparam logic [7:0] OP_FIX_PC   = 8'd9;
    localparam logic [7:0] EXT_END_SEQ = 8'd1;
    localparam logic [7:0] EXT_SET_ADR = 8'd2;

    // controller -> datapath
    typedef struct packed {
        logic       load;     // accept byte: run one parse step
        logic       div_step; // one restoring-divide step
        logic       mul_step; // apply product of registered operand
        logic       emitted;  // result taken
    } dlpd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [3:0] phase;    // phase taken at the coming edge
        logic       busy;     // multi-cycle work pending
        logic       have_res;
        logic       div_done;
    } dlpd_sts_t;
endpackage

// File: hw/rtl/dlpd_ctrl.sv
//------------------------------------------------------------------------------
// dlpd_ctrl
// Handshake controller: gates input acceptance and sequences multi-cycle steps.
//------------------------------------------------------------------------------
module dlpd_ctrl
    import dlpd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  dlpd_sts_t sts,
    output dlpd_cmd_t cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_OUT: begin
                m_tvalid    = 1'b1;
                cmd.emitted = m_tready;
            end
            default: ;
        endcase
    end

    // follow the phase the datapath enters at this edge
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE, ST_MUL: begin
                if (state_reg == ST_MUL || s_tvalid) begin
                    if (sts.phase == PH_ADV) state_next = ST_MUL;
                    else if (sts.phase == PH_SPEC) state_next = ST_DIV;
                    else if (sts.phase == PH_EMIT) state_next = ST_OUT;
                    else state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (sts.div_done) state_next = ST_MUL;
            end
            ST_OUT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end
endmodule

// File: hw/rtl/dlpd_datapath.sv
//------------------------------------------------------------------------------
// dlpd_datapath
// Line registers, LEB128 accumulator, shared divider and multiplier.
//------------------------------------------------------------------------------
module dlpd_datapath
    import dlpd_pkg::*;
#(
    parameter int EXT_LENGTH_BITS = EXT_LENGTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic [7:0]  in_byte,
    input  logic        in_end,
    input  dlpd_cmd_t   cmd,
    output dlpd_sts_t   sts,
    output logic [1:0]  o_kind,
    output logic [63:0] o_addr,
    output logic [63:0] o_file,
    output logic [31:0] o_line,
    output logic [31:0] o_col,
    output logic        o_stmt
);
    localparam int LB = EXT_LENGTH_BITS;

    logic [7:0]  min_len_reg, lbase_reg, lrange_reg, opbase_reg;
    logic        dstmt_reg;

    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  ret_reg, ret_next;        // phase after multi-cycle step
    logic [63:0] addr_reg, addr_next, file_reg, file_next;
    logic [31:0] line_reg, line_next, col_reg, col_next;
    logic        stmt_reg, stmt_next;
    logic [63:0] acc_reg, acc_next;
    logic [6:0]  shift_reg, shift_next;
    logic [7:0]  pend_reg, pend_next;
    logic [LB-1:0] rem_reg, rem_next, tot_reg, tot_next;
    logic        end_reg, end_next;        // unit end pending after step
    logic [1:0]  kind_reg, kind_next;
    logic        line_mv_reg, line_mv_next;
    logic [63:0] mul_a_reg, mul_a_next;
    // divider
    logic [7:0]  dq_reg, dq_next;
    logic [8:0]  dr_reg, dr_next;
    logic [3:0]  dcnt_reg, dcnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= 8'd1;
            dstmt_reg   <= 1'b1;
            lbase_reg   <= 8'hfb;
            lrange_reg  <= 8'd14;
            opbase_reg  <= 8'd13;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MIN_INSTR:  min_len_reg <= cfg_data;
                CFG_DEF_STMT:   dstmt_reg   <= cfg_data[0];
                CFG_LINE_BASE:  lbase_reg   <= cfg_data;
                CFG_LINE_RANGE: lrange_reg  <= cfg_data;
                CFG_OPC_BASE:   opbase_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [63:0] leb_acc;
    logic [6:0]  leb_sh;
    logic        leb_cont, leb_ovf;
    logic [LB-1:0] pay_idx;
    logic [63:0] product;
    logic [8:0]  lr9, dtry;
    logic [7:0]  adj;
    logic        err;

    assign product = mul_a_reg * {56'd0, min_len_reg};
    assign lr9 = (lrange_reg == 8'd0) ? 9'd256 : {1'b0, lrange_reg};
    assign dtry = {dr_reg[7:0], dq_reg[7]};
    assign pay_idx = (tot_reg - LB'(1)) - rem_reg;

    always_comb begin
        leb_acc  = acc_reg;
        if (shift_reg < 7'd64) leb_acc = acc_reg | ({57'd0, in_byte[6:0]} << shift_reg);
        leb_sh   = shift_reg + 7'd7;
        leb_cont = in_byte[7];
        leb_ovf  = leb_cont && (leb_sh > 7'd63);
    end

    // common unit-end handling after a step finishes in phase p
    function automatic logic trunc_at(input logic [3:0] p);
        trunc_at = (p != PH_OPC) && (p != PH_DISCARD);
    endfunction

    always_comb begin
        phase_next = phase_reg; ret_next = ret_reg;
        addr_next = addr_reg; file_next = file_reg; line_next = line_reg;
        col_next = col_reg; stmt_next = stmt_reg; acc_next = acc_reg;
        shift_next = shift_reg; pend_next = pend_reg; rem_next = rem_reg;
        tot_next = tot_reg; end_next = end_reg; kind_next = kind_reg;
        line_mv_next = line_mv_reg; mul_a_next = mul_a_reg;
        dq_next = dq_reg; dr_next = dr_reg; dcnt_next = dcnt_reg;
        adj = 8'd0; err = 1'b0;
        if (cmd.load) begin
            end_next = in_end;
            kind_next = KIND_ROW;
            case (phase_reg)
                PH_OPC: begin
                    if (in_byte == OP_EXT) begin
                        acc_next = '0; shift_next = '0; phase_next = PH_EXT_LEN;
                    end else if (in_byte < opbase_reg) begin
                        case (in_byte)
                            OP_COPY: phase_next = PH_EMIT;
                            OP_ADV_PC, OP_SET_FILE, OP_SET_COL: begin
                                pend_next = in_byte; acc_next = '0; shift_next = '0;
                                phase_next = PH_ULEB;
                            end
                            OP_ADV_LINE: begin
                                pend_next = in_byte; acc_next = '0; shift_next = '0;
                                phase_next = PH_SLEB;
                            end
                            OP_NEG_STMT: stmt_next = ~stmt_reg;
                            OP_CONST_PC: begin
                                adj = 8'd255 - opbase_reg; line_mv_next = 1'b0;
                            end
                            OP_FIX_PC: phase_next = PH_FIX_LO;
                            default: ;
                        endcase
                        if (in_byte == OP_CONST_PC) begin
                            dq_next = adj; dr_next = '0; dcnt_next = '0;
                            ret_next = PH_OPC; phase_next = PH_SPEC;
                        end
                    end else begin
                        adj = in_byte - opbase_reg; line_mv_next = 1'b1;
                        dq_next = adj; dr_next = '0; dcnt_next = '0;
                        ret_next = PH_EMIT; phase_next = PH_SPEC;
                    end
                end
                PH_EXT_LEN: begin
                    acc_next = leb_acc; shift_next = leb_sh;
                    if (leb_ovf) err = 1'b1;
                    else if (!leb_cont) begin
                        if (LB < 64 && (leb_acc >> LB) != 64'd0) err = 1'b1;
                        else if (leb_acc == 64'd0) phase_next = PH_OPC;
                        else begin
                            tot_next = leb_acc[LB-1:0]; phase_next = PH_EXT_OP;
                        end
                    end
                end
                PH_EXT_OP: begin
                    pend_next = in_byte; rem_next = tot_reg - LB'(1); acc_next = '0;
                    phase_next = (tot_reg == LB'(1)) ? PH_OPC : PH_EXT_PAY;
                end
                PH_EXT_PAY: begin
                    if (pay_idx < LB'(8))
                        acc_next = acc_reg | ({56'd0, in_byte} << {pay_idx[2:0], 3'b000});
                    rem_next = rem_reg - LB'(1);
                    if (rem_reg == LB'(1)) phase_next = PH_OPC;
                end
                PH_ULEB, PH_SLEB: begin
                    acc_next = leb_acc; shift_next = leb_sh;
                    if (leb_ovf) err = 1'b1;
                    else if (!leb_cont) begin
                        if (phase_reg == PH_SLEB && leb_sh < 7'd64 && in_byte[6])
                            acc_next = leb_acc | (~64'd0 << leb_sh);
                        phase_next = PH_OPC;
                        case (pend_reg)
                            OP_ADV_PC: begin
                                mul_a_next = leb_acc; ret_next = PH_OPC;
                                phase_next = PH_ADV;
                            end
                            OP_ADV_LINE: line_next = line_reg + acc_next[31:0];
                            OP_SET_FILE: file_next = leb_acc;
                            default: col_next = leb_acc[31:0];
                        endcase
                    end
                end
                PH_FIX_LO: begin
                    acc_next = {56'd0, in_byte}; phase_next = PH_FIX_HI;
                end
                PH_FIX_HI: begin
                    addr_next = addr_reg + {48'd0, in_byte, acc_reg[7:0]};
                    phase_next = PH_OPC;
                end
                default: ;
            endcase
            // finishing an extended op
            if ((phase_reg == PH_EXT_OP && tot_reg == LB'(1)) ||
                (phase_reg == PH_EXT_PAY && rem_reg == LB'(1))) begin
                if (((phase_reg == PH_EXT_OP) ? in_byte : pend_reg) == EXT_END_SEQ) begin
                    addr_next = '0; file_next = 64'd1; line_next = 32'd1; col_next = '0;
                    stmt_next = dstmt_reg;
                end else if (pend_reg == EXT_SET_ADR && phase_reg == PH_EXT_PAY) begin
                    if (tot_reg == LB'(9)) addr_next = acc_next;
                    else if (tot_reg == LB'(5)) addr_next = {32'd0, acc_next[31:0]};
                end
            end
            if (err) begin
                kind_next = KIND_OVF; phase_next = PH_EMIT;
            end else if (in_end && phase_next != PH_SPEC && phase_next != PH_ADV &&
                         phase_next != PH_EMIT && trunc_at(phase_next)) begin
                kind_next = KIND_TRUNC; phase_next = PH_EMIT;
            end
            if (phase_next == PH_SPEC || phase_next == PH_ADV || phase_next == PH_EMIT) begin
                // unit end deferred until step done
            end else if (in_end) begin
                phase_next = PH_OPC; addr_next = '0; file_next = 64'd1; line_next = 32'd1;
                col_next = '0; stmt_next = dstmt_reg; end_next = 1'b0;
            end
        end else if (cmd.div_step) begin
            // one restoring-divide step
            if (dtry >= lr9) begin
                dr_next = dtry - lr9; dq_next = {dq_reg[6:0], 1'b1};
            end else begin
                dr_next = dtry; dq_next = {dq_reg[6:0], 1'b0};
            end
            dcnt_next = dcnt_reg + 4'd1;
            if (dcnt_reg == 4'd7) begin
                mul_a_next = {56'd0, dq_next};
                if (line_mv_reg)
                    line_next = line_reg + {{24{lbase_reg[7]}}, lbase_reg} +
                                {24'd0, dr_next[7:0]};
                phase_next = PH_ADV;
            end
        end else if (cmd.mul_step) begin
            addr_next = addr_reg + product;
            phase_next = ret_reg;
            if (ret_reg != PH_EMIT && end_reg) begin
                phase_next = PH_OPC; addr_next = '0; file_next = 64'd1; line_next = 32'd1;
                col_next = '0; stmt_next = dstmt_reg; end_next = 1'b0;
            end
        end else if (cmd.emitted) begin
            phase_next = (kind_reg == KIND_ROW) ? PH_OPC : PH_DISCARD;
            if (end_reg) begin
                phase_next = PH_OPC; addr_next = '0; file_next = 64'd1; line_next = 32'd1;
                col_next = '0; stmt_next = dstmt_reg; end_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_OPC; end_reg <= 1'b0;
            addr_reg <= '0; file_reg <= 64'd1; line_reg <= 32'd1; col_reg <= '0;
            stmt_reg <= 1'b1; acc_reg <= '0; shift_reg <= '0; pend_reg <= '0;
            rem_reg <= '0; tot_reg <= '0;
        end else begin
            phase_reg <= phase_next; end_reg <= end_next;
            addr_reg <= addr_next; file_reg <= file_next; line_reg <= line_next;
            col_reg <= col_next; stmt_reg <= stmt_next; acc_reg <= acc_next;
            shift_reg <= shift_next; pend_reg <= pend_next;
            rem_reg <= rem_next; tot_reg <= tot_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg <= ret_next; kind_reg <= kind_next; line_mv_reg <= line_mv_next;
        mul_a_reg <= mul_a_next; dq_reg <= dq_next; dr_reg <= dr_next;
        dcnt_reg <= dcnt_next;
    end

    logic is_row;
    assign is_row = (kind_reg == KIND_ROW);
    assign o_kind = kind_reg;
    assign o_addr = is_row ? addr_reg : '0;
    assign o_file = is_row ? file_reg : '0;
    assign o_line = is_row ? line_reg : '0;
    assign o_col  = is_row ? col_reg  : '0;
    assign o_stmt = is_row ? stmt_reg : 1'b0;

    assign sts.phase    = phase_next;
    assign sts.busy     = (phase_reg == PH_SPEC) || (phase_reg == PH_ADV);
    assign sts.have_res = (phase_reg == PH_EMIT);
    assign sts.div_done = (dcnt_reg == 4'd7);
endmodule

// File: hw/rtl/dwarf_line_program_decoder.sv
//------------------------------------------------------------------------------
// dwarf_line_program_decoder
// Line-number program decoder: bytes in, rows and error results out.
//------------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)                           tuser
// s_       in   program_byte[7:0]                                   -
//               unit_end travels as s_tlast
// m_       out  address[63:0] file[127:64] line[159:128]            result_kind
//               column[191:160] is_stmt[192], zero pad to 200 bits
//
// Plain opcode and operand bytes need no extra step.
// An address advance adds a multiply step (multiplier by min_instr_length).
// A special opcode or const_add_pc adds an 8-step divider, then the
// multiply step. A result is held on the output until m_tready.
// Reset is synchronous, active low; configuration registers take reset values.
//------------------------------------------------------------------------------
module dwarf_line_program_decoder
    import dlpd_pkg::*;
#(
    parameter int EXT_LENGTH_BITS = EXT_LENGTH_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [7:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // program_byte
    input  logic         s_tlast,   // unit_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // address, file, line, column, is_stmt
    output logic [1:0]   m_tuser    // result_kind
);
    `include "dwarf_line_program_decoder_macros.svh"

    dlpd_cmd_t cmd;
    dlpd_sts_t sts;
    logic [63:0] r_addr, r_file;
    logic [31:0] r_line, r_col;
    logic        r_stmt;

    dlpd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .sts(sts), .cmd(cmd)
    );

    dlpd_datapath #(.EXT_LENGTH_BITS(EXT_LENGTH_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_byte(s_tdata), .in_end(s_tlast), .cmd(cmd),
        .sts(sts), .o_kind(m_tuser), .o_addr(r_addr), .o_file(r_file),
        .o_line(r_line), .o_col(r_col), .o_stmt(r_stmt)
    );

    assign m_tdata = {7'd0, r_stmt, r_col, r_line, r_file, r_addr};

    `DLPD_ASSERT_IMP(a_no_in_while_out, aclk, aresetn, m_tvalid, !s_tready)
    `DLPD_ASSERT_IMP(a_out_phase, aclk, aresetn, m_tvalid, sts.have_res)
    `DLPD_ASSERT_IMP(a_busy_blocks, aclk, aresetn, sts.busy, !s_tready)
    `DLPD_ASSERT_IMP(a_err_zero, aclk, aresetn, m_tvalid && m_tuser != KIND_ROW,
                     m_tdata == '0)
endmodule
